// ===== design/cabwq_pkg.sv =====
// Shared types, constants and helpers of the class-aware bounded write queue.
`default_nettype none
package cabwq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int OP_W        = 2;
  localparam int PAYLOAD_W   = 32;
  localparam int KIND_W      = 2;
  localparam int OCC_W       = 5;
  localparam int DROPS_W     = 32;
  localparam int LIMIT_W     = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_IDX_W   = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMIT = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PROBE = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    DROP_NONE        = 2'd0,
    DROP_TELE_EVICT  = 2'd1,
    DROP_CMD_DROP    = 2'd2,
    DROP_TELE_REJECT = 2'd3
  } drop_t;

  typedef struct packed {
    logic                 is_command;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } mem_wr_t;

  typedef struct packed {
    logic                 push_stored;
    drop_t                drop_kind;
    logic                 pop_valid;
    logic [PAYLOAD_W-1:0] pop_payload;
    logic                 pop_is_command;
    logic                 probe_due;
    logic [OCC_W-1:0]     occupancy;
    logic [DROPS_W-1:0]   telemetry_drops;
    logic [DROPS_W-1:0]   command_drops;
    logic                 stopped;
  } out_item_t;

  // Circular-buffer slot of the entry at offset off from the head.
  function automatic logic [ADDR_W-1:0] wrap_idx(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/cabwq_in_if.sv =====
// Input channel of the write queue: operation, task class and task handle.
`default_nettype none
interface cabwq_in_if;
  import cabwq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic                 is_command;
  logic [PAYLOAD_W-1:0] task_payload;

  modport source(output valid, output operation, output is_command, output task_payload,
                 input ready);
  modport sink(input valid, input operation, input is_command, input task_payload,
               output ready);
endinterface
`default_nettype wire

// ===== design/cabwq_out_if.sv =====
// Result channel of the write queue: one status item per accepted operation.
`default_nettype none
interface cabwq_out_if;
  import cabwq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 push_stored;
  logic [KIND_W-1:0]    drop_kind;
  logic                 pop_valid;
  logic [PAYLOAD_W-1:0] pop_payload;
  logic                 pop_is_command;
  logic                 probe_due;
  logic [OCC_W-1:0]     occupancy;
  logic [DROPS_W-1:0]   telemetry_drops;
  logic [DROPS_W-1:0]   command_drops;
  logic                 stopped;

  modport source(output valid, output push_stored, output drop_kind, output pop_valid,
                 output pop_payload, output pop_is_command, output probe_due,
                 output occupancy, output telemetry_drops, output command_drops,
                 output stopped, input ready);
  modport sink(input valid, input push_stored, input drop_kind, input pop_valid,
               input pop_payload, input pop_is_command, input probe_due,
               input occupancy, input telemetry_drops, input command_drops,
               input stopped, output ready);
endinterface
`default_nettype wire

// ===== design/cabwq_store.sv =====
// Entry store of the write queue: one write port and one registered read port.
`default_nettype none
module cabwq_store (
  input  logic                        clk,
  input  cabwq_pkg::mem_wr_t          wr,
  input  logic [cabwq_pkg::ADDR_W-1:0] rd_addr,
  output cabwq_pkg::entry_t           rd_data
);
  import cabwq_pkg::*;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== design/class_aware_bounded_write_queue.sv =====
// Top level of the class-aware bounded write queue with its sequencer and register port.
`default_nettype none
// A circular queue of up to QUEUE_DEPTH write tasks, each a command or telemetry, held in an
// entry store with one write port and one registered read port, and worked on one operation
// at a time by a small sequencer. A push at the capacity limit walks the queue from the head
// for the oldest telemetry entry, reading and then checking each entry, and then closes the
// gap by moving each later entry one slot, a read and then a write per entry. If there is no
// telemetry entry, a command push drops the oldest entry and a telemetry push is rejected.
// A finished result waits in the output register while the next operation is taken.
module class_aware_bounded_write_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  cabwq_in_if.sink                        in_ch,
  cabwq_out_if.source                     out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [cabwq_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [cabwq_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [cabwq_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import cabwq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_APPEND,
    S_POP_RD,
    S_POP_GET,
    S_FINISH
  } state_t;

  state_t               state_r;
  logic [ADDR_W-1:0]    head_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     idx_r;
  logic [DROPS_W-1:0]   tele_r;
  logic [DROPS_W-1:0]   cmd_r;
  logic                 probe_r;
  logic                 stop_r;
  logic [LIMIT_W-1:0]   limit_r;
  logic                 cls_r;
  logic [PAYLOAD_W-1:0] pay_r;
  out_item_t            res_r;
  out_item_t            out_r;
  logic                 out_valid_r;

  mem_wr_t              mem_wr;
  logic [ADDR_W-1:0]    rd_addr;
  entry_t               rd_data;

  logic [CNT_W-1:0]     eff_limit;
  logic [CNT_W:0]       idx_inc;
  logic [CNT_W:0]       count_x;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;
  logic                 in_xfer;
  logic                 out_xfer;
  logic [ADDR_W-1:0]    head_inc;
  logic                 probe_hit;
  out_item_t            res_init;
  out_item_t            fin_item;

  cabwq_store u_store (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_idx == REG_DEPTH_LIMIT) ? CFG_DATA_W'(limit_r) : '0;

  assign idx_inc  = {1'b0, idx_r} + (CNT_W+1)'(1);
  assign count_x  = {1'b0, count_r};
  assign head_inc = wrap_idx(head_r, CNT_W'(1));

  assign probe_hit = (op_t'(in_ch.operation) == OP_POP) && (count_r == '0) && !stop_r &&
                     probe_r;

  always_comb begin
    res_init           = '0;
    res_init.probe_due = probe_hit;
  end

  always_comb begin
    fin_item                 = res_r;
    fin_item.occupancy       = OCC_W'(count_r);
    fin_item.telemetry_drops = tele_r;
    fin_item.command_drops   = cmd_r;
    fin_item.stopped         = stop_r;
  end

  always_comb begin
    if (limit_r == '0) begin
      eff_limit = CNT_W'(1);
    end else if (32'(limit_r) > QUEUE_DEPTH) begin
      eff_limit = CNT_W'(QUEUE_DEPTH);
    end else begin
      eff_limit = CNT_W'(limit_r);
    end
  end

  always_comb begin
    mem_wr  = '0;
    rd_addr = wrap_idx(head_r, idx_r);
    case (state_r)
      S_SHIFT_RD: begin
        rd_addr = wrap_idx(head_r, idx_inc[CNT_W-1:0]);
      end
      S_SHIFT_WR: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = wrap_idx(head_r, idx_r);
        mem_wr.data = rd_data;
      end
      S_APPEND: begin
        if (count_r < CNT_W'(QUEUE_DEPTH)) begin
          mem_wr.en              = 1'b1;
          mem_wr.addr            = wrap_idx(head_r, count_r);
          mem_wr.data.is_command = cls_r;
          mem_wr.data.payload    = pay_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      tele_r      <= '0;
      cmd_r       <= '0;
      probe_r     <= 1'b0;
      stop_r      <= 1'b0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && (cfg_idx == REG_DEPTH_LIMIT)) begin
        limit_r <= cfg_pwdata[LIMIT_W-1:0];
      end
      if (out_xfer && (state_r != S_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            cls_r <= in_ch.is_command;
            pay_r <= in_ch.task_payload;
            res_r <= res_init;
            idx_r <= '0;
            case (op_t'(in_ch.operation))
              OP_PUSH: begin
                if (stop_r) begin
                  state_r <= S_FINISH;
                end else if (count_r >= eff_limit) begin
                  state_r <= S_SCAN_RD;
                end else begin
                  state_r <= S_APPEND;
                end
              end
              OP_POP: begin
                if (count_r != '0) begin
                  state_r <= S_POP_RD;
                end else begin
                  if (!stop_r && probe_r) begin
                    probe_r <= 1'b0;
                  end
                  state_r <= S_FINISH;
                end
              end
              OP_PROBE: begin
                if (!stop_r) begin
                  probe_r <= 1'b1;
                end
                state_r <= S_FINISH;
              end
              OP_STOP: begin
                stop_r  <= 1'b1;
                state_r <= S_FINISH;
              end
              default: begin
                state_r <= S_FINISH;
              end
            endcase
          end
        end
        S_SCAN_RD: begin
          state_r <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (!rd_data.is_command) begin
            res_r.drop_kind <= DROP_TELE_EVICT;
            tele_r          <= (tele_r == '1) ? tele_r : tele_r + DROPS_W'(1);
            state_r         <= S_SHIFT_CHK;
          end else if (idx_inc == count_x) begin
            if (cls_r) begin
              res_r.drop_kind <= DROP_CMD_DROP;
              cmd_r           <= (cmd_r == '1) ? cmd_r : cmd_r + DROPS_W'(1);
              head_r          <= head_inc;
              count_r         <= count_r - CNT_W'(1);
              state_r         <= S_APPEND;
            end else begin
              res_r.drop_kind <= DROP_TELE_REJECT;
              tele_r          <= (tele_r == '1) ? tele_r : tele_r + DROPS_W'(1);
              state_r         <= S_FINISH;
            end
          end else begin
            idx_r   <= idx_inc[CNT_W-1:0];
            state_r <= S_SCAN_RD;
          end
        end
        S_SHIFT_CHK: begin
          if (idx_inc < count_x) begin
            state_r <= S_SHIFT_RD;
          end else begin
            count_r <= count_r - CNT_W'(1);
            state_r <= S_APPEND;
          end
        end
        S_SHIFT_RD: begin
          state_r <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          idx_r   <= idx_inc[CNT_W-1:0];
          state_r <= S_SHIFT_CHK;
        end
        S_APPEND: begin
          if (count_r < CNT_W'(QUEUE_DEPTH)) begin
            count_r           <= count_r + CNT_W'(1);
            res_r.push_stored <= 1'b1;
          end
          state_r <= S_FINISH;
        end
        S_POP_RD: begin
          state_r <= S_POP_GET;
        end
        S_POP_GET: begin
          res_r.pop_valid      <= 1'b1;
          res_r.pop_payload    <= rd_data.payload;
          res_r.pop_is_command <= rd_data.is_command;
          head_r               <= head_inc;
          count_r              <= count_r - CNT_W'(1);
          state_r              <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid_r || out_ch.ready) begin
            out_r       <= fin_item;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.push_stored     = out_r.push_stored;
  assign out_ch.drop_kind       = out_r.drop_kind;
  assign out_ch.pop_valid       = out_r.pop_valid;
  assign out_ch.pop_payload     = out_r.pop_payload;
  assign out_ch.pop_is_command  = out_r.pop_is_command;
  assign out_ch.probe_due       = out_r.probe_due;
  assign out_ch.occupancy       = out_r.occupancy;
  assign out_ch.telemetry_drops = out_r.telemetry_drops;
  assign out_ch.command_drops   = out_r.command_drops;
  assign out_ch.stopped         = out_r.stopped;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("Queue occupancy exceeds its depth.");

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> stop_r)
    else $error("Stop flag cleared without reset.");

  a_tele_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> tele_r >= $past(tele_r))
    else $error("Telemetry drop total decreased.");
`endif

endmodule
`default_nettype wire
